@@ hw/rtl/mprf_pkg.sv @@
// ----------------------------------------------------------------------------
// mprf_pkg
// Types, character codes and register indexes for the mesh packet repeat
// filter, and the default sizes used by its packet store.
// ----------------------------------------------------------------------------
package mprf_pkg;

    // Default sizes handed to the top level as parameter defaults.
    localparam int PACKET_BYTES_DEF = 48;
    localparam int NAME_BYTES_DEF   = 8;

    // A forwarded packet never exceeds this many result beats.
    localparam int MAX_RESULTS = 58;

    // Width used when comparing small counts of differing widths.
    localparam int CMP_W = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NAME        = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NAME_LENGTH = 4'd1;

    // Character codes used by the path scan.
    localparam logic [7:0] CH_OPEN  = 8'h5B;   // '['
    localparam logic [7:0] CH_COMMA = 8'h2C;   // ','
    localparam logic [7:0] CH_CLOSE = 8'h5D;   // ']'
    localparam logic [7:0] CH_ZERO  = 8'h30;   // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;   // '9'
    localparam logic [7:0] CH_LOW_A = 8'h61;   // 'a'
    localparam logic [7:0] CH_LOW_Z = 8'h7A;   // 'z'

    typedef enum logic [1:0] {
        VERDICT_FORWARD  = 2'd0,
        VERDICT_REPEATED = 2'd1,
        VERDICT_HOPS_OUT = 2'd2,
        VERDICT_NOT_MESH = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_last;
        t_verdict    verdict;
        logic [31:0] received_total;
        logic [31:0] repeated_total;
    } t_out_beat;

endpackage

@@ hw/rtl/mprf_store.sv @@
// ----------------------------------------------------------------------------
// mprf_store
// Packet byte buffer: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module mprf_store #(
    parameter int DEPTH = mprf_pkg::PACKET_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]               i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [7:0]               o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/mesh_packet_repeat_filter_unit.sv @@
// ----------------------------------------------------------------------------
// mesh_packet_repeat_filter_unit
// Each input beat is accepted (S_IDLE), then scanned (S_SCAN); the final
// beat adds a decision step (S_DECIDE). A forwarded byte is read from the
// store (S_READ), then loaded into the output register (S_PUT); the comma,
// name bytes and closing bracket, or a verdict, each go through the single output register.
// Reset is synchronous and clears control state, totals and configuration; the store is not swept.
// ----------------------------------------------------------------------------
module mesh_packet_repeat_filter_unit #(
    parameter int PACKET_BYTES = mprf_pkg::PACKET_BYTES_DEF,
    parameter int NAME_BYTES   = mprf_pkg::NAME_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input byte channel.
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  mprf_pkg::t_in_beat               i_in_data,
    // Result channel.
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output mprf_pkg::t_out_beat              o_out_data,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mprf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mprf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // Index into the store, and a count that can also hold the depth itself.
    localparam int IDX_W = $clog2(PACKET_BYTES);
    localparam int CNT_W = $clog2(PACKET_BYTES + 1);
    localparam int CW    = mprf_pkg::CMP_W;

    // The sequencer: one beat is scanned, or one result beat is produced,
    // per step. The output register is shared by every result beat.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_READ,
        S_PUT,
        S_COMMA,
        S_NAME,
        S_CLOSE,
        S_VERDICT
    } t_state;

    t_state               r_state;
    mprf_pkg::t_in_beat   r_in;

    // Per-packet scan state.
    logic [CNT_W-1:0]     r_byte_count;
    logic [CNT_W-1:0]     r_seg_start;
    logic [IDX_W-1:0]     r_last_close;
    logic                 r_seen;
    logic                 r_match;
    logic [7:0]           r_byte0;
    logic [7:0]           r_byte1;

    // Running totals, kept across packets.
    logic [31:0]          r_received;
    logic [31:0]          r_repeated;

    // Configuration.
    logic [63:0]          r_own_name;
    logic [3:0]           r_own_len;

    // Emission control.
    logic [IDX_W-1:0]     r_prefix;
    logic [IDX_W-1:0]     r_idx;
    logic [3:0]           r_name_idx;
    mprf_pkg::t_verdict   r_verdict;

    // Output register.
    logic                 r_out_valid;
    mprf_pkg::t_out_beat  r_out;

    logic [7:0]           rd_data;
    logic [3:0]           name_len;
    logic                 room;
    logic                 is_delim;
    logic [CNT_W-1:0]     seg_offset;
    logic [7:0]           scan_char;
    logic                 is_mesh;
    logic [CW-1:0]        prefix_limit;
    logic [CW-1:0]        close_wide;
    logic                 slot_free;

    // The name length saturates at the number of name bytes provided.
    assign name_len = (r_own_len > 4'(NAME_BYTES)) ? 4'(NAME_BYTES) : r_own_len;

    // A byte beyond the store's depth is neither stored nor scanned.
    assign room       = (r_byte_count < CNT_W'(PACKET_BYTES));
    assign is_delim   = (r_in.rx_byte == mprf_pkg::CH_OPEN)  ||
                        (r_in.rx_byte == mprf_pkg::CH_COMMA) ||
                        (r_in.rx_byte == mprf_pkg::CH_CLOSE);
    assign seg_offset = r_byte_count - r_seg_start;
    assign scan_char  = r_own_name[{seg_offset[2:0], 3'b000} +: 8];

    assign is_mesh = (r_byte_count >= CNT_W'(2)) &&
                     (r_byte0 >= mprf_pkg::CH_ZERO)  && (r_byte0 <= mprf_pkg::CH_NINE) &&
                     (r_byte1 >= mprf_pkg::CH_LOW_A) && (r_byte1 <= mprf_pkg::CH_LOW_Z);

    // The forwarded prefix is cut so the whole packet fits the result limit.
    assign prefix_limit = CW'(mprf_pkg::MAX_RESULTS - 2) - CW'(name_len);
    assign close_wide   = CW'(r_last_close);

    // The output register can take a new beat when empty or being drained.
    assign slot_free = !r_out_valid || !i_out_stall;

    mprf_store #(
        .DEPTH     (PACKET_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   ((r_state == S_SCAN) && room),
        .i_wr_addr (r_byte_count[IDX_W-1:0]),
        .i_wr_data (r_in.rx_byte),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_byte_count <= '0;
            r_seg_start  <= '0;
            r_last_close <= '0;
            r_seen       <= 1'b0;
            r_match      <= 1'b1;
            r_received   <= '0;
            r_repeated   <= '0;
            r_own_name   <= '0;
            r_own_len    <= 4'd1;
            r_out_valid  <= 1'b0;
        end else begin
            // Configuration writes are taken in any cycle; unknown indexes
            // are ignored.
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    mprf_pkg::CFG_OWN_NAME:        r_own_name <= i_cfg_data;
                    mprf_pkg::CFG_OWN_NAME_LENGTH: r_own_len  <= i_cfg_data[3:0];
                    default: ;
                endcase
            end

            // The output register empties once its beat has been taken.
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_state <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    // Store the byte and follow the path segments: a segment
                    // opens after a delimiter and is checked character by
                    // character against the node name.
                    if (room) begin
                        r_byte_count <= r_byte_count + CNT_W'(1);
                        if (r_byte_count == CNT_W'(0)) begin
                            r_byte0 <= r_in.rx_byte;
                        end
                        if (r_byte_count == CNT_W'(1)) begin
                            r_byte1 <= r_in.rx_byte;
                        end
                        if (is_delim) begin
                            if ((r_seg_start != '0) && r_match &&
                                (CW'(seg_offset) == CW'(name_len))) begin
                                r_seen <= 1'b1;
                            end
                            r_seg_start <= r_byte_count + CNT_W'(1);
                            r_match     <= 1'b1;
                            if (r_in.rx_byte == mprf_pkg::CH_CLOSE) begin
                                r_last_close <= r_byte_count[IDX_W-1:0];
                            end
                        end else if (r_seg_start != '0) begin
                            if ((CW'(seg_offset) >= CW'(name_len)) ||
                                (r_in.rx_byte != scan_char)) begin
                                r_match <= 1'b0;
                            end
                        end
                    end
                    r_state <= r_in.rx_last ? S_DECIDE : S_IDLE;
                end

                S_DECIDE: begin
                    r_idx      <= '0;
                    r_name_idx <= '0;
                    if (!is_mesh) begin
                        r_verdict <= mprf_pkg::VERDICT_NOT_MESH;
                        r_state   <= S_VERDICT;
                    end else begin
                        r_received <= r_received + 32'd1;
                        if (r_seen) begin
                            r_verdict <= mprf_pkg::VERDICT_REPEATED;
                            r_state   <= S_VERDICT;
                        end else if (r_byte0 == mprf_pkg::CH_ZERO) begin
                            r_verdict <= mprf_pkg::VERDICT_HOPS_OUT;
                            r_state   <= S_VERDICT;
                        end else begin
                            r_repeated <= r_repeated + 32'd1;
                            if (close_wide > prefix_limit) begin
                                r_prefix <= prefix_limit[IDX_W-1:0];
                            end else begin
                                r_prefix <= r_last_close;
                            end
                            if ((close_wide == '0) || (prefix_limit == '0)) begin
                                r_state <= S_COMMA;
                            end else begin
                                r_state <= S_READ;
                            end
                        end
                    end
                end

                S_READ: begin
                    r_state <= S_PUT;
                end

                S_PUT: begin
                    if (slot_free) begin
                        r_out_valid          <= 1'b1;
                        // The hop digit goes out one lower.
                        r_out.tx_byte        <= (r_idx == '0) ? (rd_data - 8'd1) : rd_data;
                        r_out.tx_last        <= 1'b0;
                        r_out.verdict        <= mprf_pkg::VERDICT_FORWARD;
                        r_out.received_total <= r_received;
                        r_out.repeated_total <= r_repeated;
                        if ((r_idx + IDX_W'(1)) == r_prefix) begin
                            r_state <= S_COMMA;
                        end else begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_READ;
                        end
                    end
                end

                S_COMMA: begin
                    if (slot_free) begin
                        r_out_valid          <= 1'b1;
                        r_out.tx_byte        <= mprf_pkg::CH_COMMA;
                        r_out.tx_last        <= 1'b0;
                        r_out.verdict        <= mprf_pkg::VERDICT_FORWARD;
                        r_out.received_total <= r_received;
                        r_out.repeated_total <= r_repeated;
                        r_state              <= (name_len == 4'd0) ? S_CLOSE : S_NAME;
                    end
                end

                S_NAME: begin
                    if (slot_free) begin
                        r_out_valid          <= 1'b1;
                        r_out.tx_byte        <= r_own_name[{r_name_idx[2:0], 3'b000} +: 8];
                        r_out.tx_last        <= 1'b0;
                        r_out.verdict        <= mprf_pkg::VERDICT_FORWARD;
                        r_out.received_total <= r_received;
                        r_out.repeated_total <= r_repeated;
                        r_name_idx           <= r_name_idx + 4'd1;
                        if ((r_name_idx + 4'd1) == name_len) begin
                            r_state <= S_CLOSE;
                        end
                    end
                end

                S_CLOSE, S_VERDICT: begin
                    if (slot_free) begin
                        r_out_valid          <= 1'b1;
                        r_out.tx_last        <= 1'b1;
                        r_out.received_total <= r_received;
                        r_out.repeated_total <= r_repeated;
                        if (r_state == S_CLOSE) begin
                            r_out.tx_byte <= mprf_pkg::CH_CLOSE;
                            r_out.verdict <= mprf_pkg::VERDICT_FORWARD;
                        end else begin
                            r_out.tx_byte <= 8'd0;
                            r_out.verdict <= r_verdict;
                        end
                        // The packet is finished: back to a clean scan state.
                        r_byte_count <= '0;
                        r_seg_start  <= '0;
                        r_last_close <= '0;
                        r_seen       <= 1'b0;
                        r_match      <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A new input beat is taken only while the sequencer is waiting for one.
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A verdict beat carries no byte and always closes its packet.
    a_verdict_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.verdict != mprf_pkg::VERDICT_FORWARD)) |->
        (r_out.tx_last && (r_out.tx_byte == 8'd0)))
        else $error("verdict beat without tx_last or with a byte");

    // The last beat of a forwarded packet is always the closing bracket.
    a_forward_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.tx_last && (r_out.verdict == mprf_pkg::VERDICT_FORWARD)) |->
        (r_out.tx_byte == mprf_pkg::CH_CLOSE))
        else $error("forwarded packet does not end in a closing bracket");

    // The byte count never runs past the store.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= CNT_W'(PACKET_BYTES))
        else $error("byte count beyond store depth");

    // A packet is only counted as repeated when it is also counted as received.
    a_totals_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_repeated != $past(r_repeated)) |-> (r_received != $past(r_received)))
        else $error("repeated total moved without the received total");

endmodule
